// ===== rtl/conditional_median_filter_macros.svh =====
// Assertion macros for the conditional median filter.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef CONDITIONAL_MEDIAN_FILTER_MACROS_SVH
`define CONDITIONAL_MEDIAN_FILTER_MACROS_SVH

// Checked on every rising edge outside of reset.
`define CMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/cmf_pkg.sv =====
// Shared types and constants of the conditional median filter.
// No dependencies; the RTL files and the testbench refer to it by scoped names.
package cmf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int HW_W     = 3;             // half_width register width
  localparam int HW_MAX   = (1 << HW_W) - 1;
  localparam int FILL_W   = HW_W + 1;      // holds twice the largest half width
  localparam int THR_W    = 16;
  localparam int TAIL_N   = HW_MAX;        // samples a record end can flush
  localparam int QDEPTH   = 4;             // power of two
  localparam int QCW      = $clog2(QDEPTH + 1);
  localparam int ADDR_W   = 3;

  localparam logic REG_HALF_WIDTH = 1'b0;
  localparam logic REG_THRESHOLD  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_in_record;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       was_replaced;
    logic                       last_out;
  } out_item_t;

  // One classified request travelling from the front end to the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0]           median;
    logic signed [SAMPLE_W-1:0]           center;
    logic [TAIL_N-1:0][SAMPLE_W-1:0]      tail;
    logic                                 use_median;
    logic                                 has_primary;
    logic [HW_W-1:0]                      flush_cnt;
    logic                                 last;
  } job_t;

endpackage

// ===== rtl/cmf_queue.sv =====
// Small register queue that decouples the front end from the back end.
// Depends on cmf_pkg for the job type and the queue depth.
module cmf_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  cmf_pkg::job_t             wr_entry,
  input  logic                      pop,
  output cmf_pkg::job_t             rd_entry,
  output logic                      empty,
  output logic                      full,
  output logic [cmf_pkg::QCW-1:0]   count
);

  localparam int PW = $clog2(cmf_pkg::QDEPTH);

  cmf_pkg::job_t            mem_r [cmf_pkg::QDEPTH];
  logic [PW-1:0]            wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic [cmf_pkg::QCW-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + cmf_pkg::QCW'(push) - cmf_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  assign rd_entry = mem_r[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign full     = (count_r == cmf_pkg::QCW'(cmf_pkg::QDEPTH));
  assign count    = count_r;

endmodule

// ===== rtl/cmf_front.sv =====
// Front end: accepts samples, keeps the sliding window and fill count,
// ranks the window in two stages and hands classified requests to the queue.
// Depends on cmf_pkg.
module cmf_front #(
  parameter int MAX_WINDOW = 15
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cmf_pkg::HW_W-1:0]      half_width,
  input  logic                          push,
  output logic                          full,
  input  cmf_pkg::in_item_t             in_item,
  input  logic [cmf_pkg::QCW-1:0]       q_count,
  output logic                          q_push,
  output cmf_pkg::job_t                 q_entry,
  output logic                          m_busy
);

  localparam int HALF_MAX = (MAX_WINDOW - 1) / 2;
  localparam int HEFF     = (HALF_MAX > cmf_pkg::HW_MAX) ? cmf_pkg::HW_MAX : HALF_MAX;
  localparam int SD       = 2 * HEFF;
  localparam int WIN      = SD + 1;
  localparam int RW       = $clog2(WIN);

  logic [cmf_pkg::HW_W-1:0]    h, pend;
  logic [cmf_pkg::FILL_W-1:0]  span, f, len, fill_r, fill_nxt;
  logic                        accept, prim, do_med, emit;

  cmf_pkg::sample_t            store_r [SD];
  cmf_pkg::sample_t            w [WIN];
  logic [WIN-1:0]              mask;
  logic [WIN-1:0][WIN-1:0]     cmp;

  logic                        m_valid_r;
  cmf_pkg::sample_t            m_w_r [WIN];
  logic [WIN-1:0]              m_mask_r;
  logic [WIN-1:0][WIN-1:0]     m_cmp_r;
  logic [cmf_pkg::HW_W-1:0]    m_h_r, m_flush_r;
  logic                        m_prim_r, m_med_r, m_last_r;

  logic [RW-1:0]               rank [WIN];
  cmf_pkg::sample_t            med;

  // Credit check: the queue must have room for the request in the rank stage too.
  assign full   = (int'(q_count) + int'(m_valid_r)) >= cmf_pkg::QDEPTH;
  assign accept = push && !full;

  always_comb begin
    h      = (half_width > cmf_pkg::HW_W'(HEFF)) ? cmf_pkg::HW_W'(HEFF) : half_width;
    span   = {h, 1'b0};
    f      = (fill_r > span) ? span : fill_r;
    len    = f + cmf_pkg::FILL_W'(1);
    pend   = (len < {1'b0, h}) ? len[cmf_pkg::HW_W-1:0] : h;
    prim   = (f >= {1'b0, h});
    do_med = (f == span);
    emit   = prim || in_item.last_in_record;
    fill_nxt = fill_r;
    if (accept) begin
      if (in_item.last_in_record) begin
        fill_nxt = '0;
      end else begin
        fill_nxt = (len >= span) ? span : len;
      end
    end
  end

  // Window: the new sample at place 0, older samples behind it.
  always_comb begin
    w[0] = in_item.sample;
    for (int k = 1; k < WIN; k++) begin
      w[k] = store_r[k-1];
    end
    for (int k = 0; k < WIN; k++) begin
      mask[k] = (cmf_pkg::FILL_W'(k) <= span);
    end
    cmp = '0;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < i; j++) begin
        cmp[j][i] = (w[j] <= w[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      m_valid_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      m_valid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[0] <= in_item.sample;
      for (int k = 1; k < SD; k++) begin
        store_r[k] <= store_r[k-1];
      end
      m_w_r     <= w;
      m_mask_r  <= mask;
      m_cmp_r   <= cmp;
      m_h_r     <= h;
      m_prim_r  <= prim;
      m_med_r   <= do_med;
      m_last_r  <= in_item.last_in_record;
      m_flush_r <= in_item.last_in_record ? pend : '0;
    end
  end

  // Rank every valid sample; equal values are ordered by position so ranks are unique.
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WIN; j++) begin
        if (j != i && m_mask_r[j]) begin
          if (j < i) begin
            rank[i] = rank[i] + RW'(m_cmp_r[j][i]);
          end else begin
            rank[i] = rank[i] + RW'(!m_cmp_r[i][j]);
          end
        end
      end
    end
    med = '0;
    for (int i = 0; i < WIN; i++) begin
      if (m_mask_r[i] && rank[i] == RW'(m_h_r)) begin
        med = m_w_r[i];
      end
    end
  end

  assign q_push              = m_valid_r;
  assign m_busy              = m_valid_r;
  assign q_entry.median      = med;
  assign q_entry.center      = m_w_r[RW'(m_h_r)];
  assign q_entry.use_median  = m_med_r;
  assign q_entry.has_primary = m_prim_r;
  assign q_entry.flush_cnt   = m_flush_r;
  assign q_entry.last        = m_last_r;

  for (genvar k = 0; k < cmf_pkg::TAIL_N; k++) begin : g_tail
    if (k < WIN) begin : g_on
      assign q_entry.tail[k] = m_w_r[k];
    end else begin : g_off
      assign q_entry.tail[k] = '0;
    end
  end

endmodule

// ===== rtl/cmf_back.sv =====
// Back end: expands each queued request into its results, applies the
// threshold test and holds the result in the output register.
// Depends on cmf_pkg.
module cmf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cmf_pkg::THR_W-1:0]    threshold,
  input  logic                         q_empty,
  input  cmf_pkg::job_t                q_head,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output cmf_pkg::out_item_t           out_item
);

  localparam int CW = cmf_pkg::HW_W + 1;
  localparam int SW = cmf_pkg::SAMPLE_W;

  logic [cmf_pkg::HW_W-1:0]  k_r, k_nxt, j, tidx;
  logic [CW-1:0]             n;
  logic                      fin, at_prim, repl, load;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SW:0]        diff;
  logic [SW:0]               mag;
  cmf_pkg::out_item_t        res, out_r;

  always_comb begin
    n       = CW'(q_head.has_primary) + CW'(q_head.flush_cnt);
    fin     = ({1'b0, k_r} == n - CW'(1));
    at_prim = q_head.has_primary && (k_r == '0);
    j       = k_r - cmf_pkg::HW_W'(q_head.has_primary);
    tidx    = q_head.flush_cnt - cmf_pkg::HW_W'(1) - j;
    diff    = {q_head.median[SW-1], q_head.median} - {q_head.center[SW-1], q_head.center};
    mag     = diff[SW] ? -diff : diff;
    repl    = q_head.use_median && (mag > {1'b0, threshold});

    res.filtered_sample = at_prim ? (repl ? q_head.median : q_head.center)
                                  : q_head.tail[tidx];
    res.was_replaced    = at_prim && repl;
    res.last_out        = fin && q_head.last;

    load  = !q_empty && (!out_valid_r || pop);
    q_pop = load && fin;
    k_nxt = k_r;
    if (load) begin
      k_nxt = fin ? '0 : k_r + cmf_pkg::HW_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

endmodule

// ===== rtl/conditional_median_filter.sv =====
// Conditional median filter, top level: configuration registers and the
// front end, queue and back end. Depends on cmf_pkg and the assertion macros.
//
// Usage. Samples enter through a queue-like port: an item is taken on a
// rising edge with push high and full low. Results leave the same way: the
// oldest result sits on out_item while empty is low and is taken on a rising
// edge with pop high. Registers half_width (address 0) and threshold
// (address 4) are written over the APB-style port; the user must write them
// only while the block is idle; the block does not enforce it. A sample's
// first result passes the rank stage, the queue and the output register.
// Throughput is one sample per cycle while full stays low; the sample that
// ends a record also flushes up to half_width held samples, one result per
// cycle while results are popped. The front end compares every pair of
// window samples as a sample is taken and ranks the registered compares in
// the next cycle; a four-entry queue lies between it and the back end.
// If the receiver stops popping, results wait in the output register,
// the queue fills and full rises, and nothing is lost.
// Reset (synchronous, active low) empties the window, the pipeline, the
// queue and the output register, and sets half_width to 1 and threshold to 0.
`include "conditional_median_filter_macros.svh"

module conditional_median_filter #(
  parameter int MAX_WINDOW = 15
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // sample channel
  input  logic                           push,
  output logic                           full,
  input  cmf_pkg::in_item_t              in_item,
  // result channel
  output logic                           empty,
  input  logic                           pop,
  output cmf_pkg::out_item_t             out_item,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cmf_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [cmf_pkg::HW_W-1:0]   half_width_r, half_width_nxt;
  logic [cmf_pkg::THR_W-1:0]  threshold_r, threshold_nxt;
  logic                       cfg_wr;

  logic                       q_push, q_pop, q_empty, q_full, m_busy;
  logic [cmf_pkg::QCW-1:0]    q_count;
  cmf_pkg::job_t              q_wr_entry, q_head;

  // Register file. The top address bit selects the register; a write lands
  // on the access phase of the transfer.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    half_width_nxt = half_width_r;
    threshold_nxt  = threshold_r;
    prdata         = '0;
    unique case (paddr[cmf_pkg::ADDR_W-1])
      cmf_pkg::REG_HALF_WIDTH: begin
        prdata = 32'(half_width_r);
        if (cfg_wr) begin
          half_width_nxt = pwdata[cmf_pkg::HW_W-1:0];
        end
      end
      cmf_pkg::REG_THRESHOLD: begin
        prdata = 32'(threshold_r);
        if (cfg_wr) begin
          threshold_nxt = pwdata[cmf_pkg::THR_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= cmf_pkg::HW_W'(1);
      threshold_r  <= '0;
    end else begin
      half_width_r <= half_width_nxt;
      threshold_r  <= threshold_nxt;
    end
  end

  // The front end keeps the window and decides, per sample, whether a
  // result is due and how many held samples a record end releases.
  cmf_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .half_width (half_width_r),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_entry    (q_wr_entry),
    .m_busy     (m_busy)
  );

  cmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_head),
    .empty    (q_empty),
    .full     (q_full),
    .count    (q_count)
  );

  // The back end turns each request into one or more results in order.
  cmf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .threshold (threshold_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

  // The credit scheme must keep the queue from ever overflowing.
  `CMF_ASSERT(a_queue_no_overflow, q_push |-> !q_full, "queue written while full")
  `CMF_ASSERT(a_queue_no_underflow, q_pop |-> !q_empty, "queue read while empty")
  `CMF_ASSERT(a_credit_bound, (int'(q_count) + int'(m_busy)) <= cmf_pkg::QDEPTH, "credit lost")
  `CMF_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> empty, "result shown right after reset")

endmodule

// ===== sim/conditional_median_filter_tb.sv =====
// Self-checking testbench for the conditional median filter: directed records, then random
// records under several register settings, with random idling on both channels.
// Depends on cmf_pkg and the conditional_median_filter RTL.
module conditional_median_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_CAP    = 15;    // largest window the block is built for
  localparam int SETTLE_CYCLES = 16;    // pipeline latency plus the longest record flush
  localparam int QUIET_LIMIT   = 3000;  // cycles without any request moving
  localparam int HOLD_CYCLES   = 150;   // length of the one long receiver hold-off
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 25;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  cmf_pkg::in_item_t             in_item = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  cmf_pkg::out_item_t            out_item;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cmf_pkg::ADDR_W-1:0]    paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Requests still to be offered, and the results the filter model says must come out.
  cmf_pkg::in_item_t             pending_samples[$];
  cmf_pkg::out_item_t            predicted_results[$];

  // Model copy of the registers and of the samples held for the current record.
  logic [cmf_pkg::HW_W-1:0]      hw_cfg = 3'd1;
  logic [cmf_pkg::THR_W-1:0]     thr_cfg = '0;
  int                            held[WINDOW_CAP];
  int                            held_cnt = 0;

  int                            fail_cnt = 0;
  int                            results_seen = 0;
  int                            walk_level = 0;

  // Idling controls; the stimulus process sets the enables per phase.
  bit                            tx_idle_en = 1'b0;
  bit                            rx_idle_en = 1'b0;
  int                            gap_left = 0;
  int                            stall_left = 0;
  int                            hold_left = 0;
  bit                            hold_done = 1'b0;
  int                            quiet_cycles = 0;
  cmf_pkg::out_item_t            want;

  always #4 clk = ~clk;

  conditional_median_filter #(
    .MAX_WINDOW(WINDOW_CAP)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .empty   (empty),
    .pop     (pop),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Filter model. Takes one accepted sample and appends the results it releases. A full
  // window yields the center sample, replaced by the window median when the two differ by
  // more than the threshold. Before the window fills, the sample half_width places back
  // leaves unchanged. The sample that ends a record also flushes the held tail.
  task automatic filter_sample(input cmf_pkg::in_item_t it);
    int                 h;
    int                 span;
    int                 f;
    int                 len;
    int                 tail;
    int                 keep;
    int                 med;
    int                 ctr;
    int                 diff;
    int                 v;
    int                 j;
    int                 win[WINDOW_CAP];
    int                 srt[WINDOW_CAP];
    cmf_pkg::out_item_t res[$];
    cmf_pkg::out_item_t r;
    h = hw_cfg;
    if (h > (WINDOW_CAP - 1) / 2) h = (WINDOW_CAP - 1) / 2;
    span = 2 * h;
    if (held_cnt > WINDOW_CAP - 1) held_cnt = WINDOW_CAP - 1;
    // A smaller half width keeps only the newest samples; the older ones are dropped.
    if (held_cnt > span) begin
      for (int i = 0; i < span; i++) held[i] = held[held_cnt - span + i];
      held_cnt = span;
    end
    f = held_cnt;
    for (int i = 0; i < f; i++) win[i] = held[i];
    win[f] = int'(it.sample);
    len = f + 1;

    if (f == span) begin
      for (int i = 0; i < len; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      med  = srt[h];
      ctr  = win[h];
      diff = (med > ctr) ? med - ctr : ctr - med;
      r.filtered_sample = (diff > int'(thr_cfg)) ? cmf_pkg::SAMPLE_W'(med)
                                                 : cmf_pkg::SAMPLE_W'(ctr);
      r.was_replaced    = (diff > int'(thr_cfg));
      r.last_out        = 1'b0;
      res.push_back(r);
    end else if (f >= h) begin
      r.filtered_sample = cmf_pkg::SAMPLE_W'(win[f-h]);
      r.was_replaced    = 1'b0;
      r.last_out        = 1'b0;
      res.push_back(r);
    end

    if (it.last_in_record) begin
      tail = (len < h) ? len : h;
      for (int i = len - tail; i < len; i++) begin
        r.filtered_sample = cmf_pkg::SAMPLE_W'(win[i]);
        r.was_replaced    = 1'b0;
        r.last_out        = 1'b0;
        res.push_back(r);
      end
      if (res.size() > 0) res[res.size()-1].last_out = 1'b1;
      held_cnt = 0;
    end else begin
      keep = (len < span) ? len : span;
      for (int i = 0; i < keep; i++) held[i] = win[len - keep + i];
      held_cnt = keep;
    end
    foreach (res[i]) predicted_results.push_back(res[i]);
  endtask

  // Sender. A request is taken at an edge with push high and full low. A request that meets
  // full is held as it is; otherwise the sender may pause for a random burst.
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        filter_sample(in_item);
        pending_samples.delete(0);
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (pending_samples.size() == 0) begin
        push <= 1'b0;
      end else if (tx_idle_en && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 18) - 1;
        push <= 1'b0;
      end else begin
        push    <= 1'b1;
        in_item <= pending_samples[0];
      end
    end
  end

  // Receiver and checker. Each result taken is compared with the oldest prediction. Once,
  // while plenty of samples are still waiting, the receiver stops popping long enough that
  // the internal queue fills and the block raises full.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          $error("unexpected result: filtered_sample %0d was_replaced %0b last_out %0b",
                 out_item.filtered_sample, out_item.was_replaced, out_item.last_out);
          fail_cnt++;
        end else begin
          want = predicted_results.pop_front();
          if (out_item.filtered_sample !== want.filtered_sample) begin
            $error("filtered_sample: expected %0d, got %0d",
                   want.filtered_sample, out_item.filtered_sample);
            fail_cnt++;
          end
          if (out_item.was_replaced !== want.was_replaced) begin
            $error("was_replaced: expected %0b, got %0b",
                   want.was_replaced, out_item.was_replaced);
            fail_cnt++;
          end
          if (out_item.last_out !== want.last_out) begin
            $error("last_out: expected %0b, got %0b", want.last_out, out_item.last_out);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (!hold_done && results_seen > 10 && pending_samples.size() > 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: only cycles in which work is outstanding yet no request moves are counted.
  always @(posedge clk) begin
    if (rst_n && ((push && !full) || (pop && !empty))) begin
      quiet_cycles = 0;
    end else if (rst_n && (pending_samples.size() > 0 || predicted_results.size() > 0)) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("conditional_median_filter_tb NOT OK");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle; pready is tied high by the block.
  task automatic write_reg(input logic idx, input int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == cmf_pkg::REG_HALF_WIDTH) hw_cfg = val[cmf_pkg::HW_W-1:0];
    else thr_cfg = val[cmf_pkg::THR_W-1:0];
  endtask

  task automatic add_sample(input int v, input bit last);
    cmf_pkg::in_item_t it;
    it.sample         = cmf_pkg::SAMPLE_W'(v);
    it.last_in_record = last;
    pending_samples.push_back(it);
  endtask

  // Waits until every sample is taken and every result is out, then lets the pipeline
  // settle, since samples that fill the window release nothing.
  task automatic settle();
    while (pending_samples.size() != 0 || predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly a slow random walk with a few spikes, so that the threshold matters; now and
  // then a sample drawn over the full range.
  function automatic int make_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 65535)) - 32768;
      1: v = walk_level + ($urandom_range(0, 1) ? 20000 : -20000);
      default: begin
        walk_level += int'($urandom_range(0, 400)) - 200;
        if (walk_level > 30000) walk_level = 30000;
        if (walk_level < -30000) walk_level = -30000;
        v = walk_level + int'($urandom_range(0, 40)) - 20;
      end
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  initial begin
    int  left;
    int  rec_len;
    bit  dummy;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, half width 1 and threshold 0: a plain three-sample median. The first
    // record runs through both extremes, small values around zero, a lone spike, ties and
    // a full-scale edge sample at the end.
    add_sample(-32768, 1'b0);
    add_sample(32767, 1'b0);
    add_sample(0, 1'b0);
    add_sample(-1, 1'b0);
    add_sample(1, 1'b0);
    add_sample(100, 1'b0);
    add_sample(5000, 1'b0);
    add_sample(100, 1'b0);
    add_sample(100, 1'b0);
    add_sample(100, 1'b0);
    add_sample(-32768, 1'b0);
    add_sample(100, 1'b0);
    add_sample(32767, 1'b1);
    // Short records: one sample, then two.
    add_sample(-12345, 1'b1);
    add_sample(21845, 1'b0);
    add_sample(-21846, 1'b1);
    settle();

    // Zero half width: every sample leaves at once, unchanged.
    write_reg(cmf_pkg::REG_HALF_WIDTH, 0);
    add_sample(32767, 1'b0);
    add_sample(-32768, 1'b0);
    add_sample(7, 1'b1);
    settle();

    // Widest window with the threshold at its top. The record is too short for a full
    // window, so all of it leaves unchanged on its last sample.
    write_reg(cmf_pkg::REG_HALF_WIDTH, 7);
    write_reg(cmf_pkg::REG_THRESHOLD, 65535);
    for (int i = 0; i < 6; i++) add_sample((i == 3) ? 32767 : -32768, i == 5);
    settle();

    // Random phases, each under its own setting. A phase may stop in the middle of a
    // record, so the next setting takes over a partly filled window.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       write_reg(cmf_pkg::REG_HALF_WIDTH, 1);
        1:       write_reg(cmf_pkg::REG_HALF_WIDTH, 7);
        default: write_reg(cmf_pkg::REG_HALF_WIDTH, $urandom_range(0, 7));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(cmf_pkg::REG_THRESHOLD, 0);
        1:       write_reg(cmf_pkg::REG_THRESHOLD, 65535);
        2:       write_reg(cmf_pkg::REG_THRESHOLD, $urandom_range(0, 300));
        default: write_reg(cmf_pkg::REG_THRESHOLD, $urandom_range(0, 65535));
      endcase
      // The last phase runs without idling on either side.
      tx_idle_en = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_en = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      left = PHASE_ITEMS;
      while (left > 0) begin
        rec_len = $urandom_range(1, 30);
        if (rec_len >= left) begin
          rec_len = left;
          dummy = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 2) != 0);
        end else begin
          dummy = 1'b1;
        end
        for (int i = 0; i < rec_len; i++) add_sample(make_sample(), dummy && i == rec_len - 1);
        left -= rec_len;
      end
      settle();
    end

    if (fail_cnt == 0 && predicted_results.size() == 0) begin
      $display("conditional_median_filter_tb OK");
    end else begin
      $display("conditional_median_filter_tb NOT OK");
    end
    $finish;
  end

endmodule
